>>> src/rgbc_to_hsl_converter_top_defines.svh
// Assertion macros used by the checker file.
`ifndef RGBC_TO_HSL_CONVERTER_TOP_DEFINES_SVH
`define RGBC_TO_HSL_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RGBHSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RGBHSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define RGBHSL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/rgbhsl_pkg.sv
package rgbhsl_pkg;

    localparam int CNT_W     = 16;
    localparam int PCT_W     = 7;
    localparam int HUE_W     = 9;
    localparam int NCH       = 3;
    localparam int PCT_NUM_W = 23;
    localparam int HUE_NUM_W = 13;
    localparam int HUE_Q_W   = 6;
    localparam int SUM_W     = 8;
    localparam int SAT_NUM_W = 14;
    localparam int SAT_Q_W   = 7;

    localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
    localparam logic [HUE_W-1:0]   HUE_FULL  = HUE_W'(360);
    localparam logic [HUE_Q_W-1:0] HUE_STEP  = HUE_Q_W'(60);
    localparam logic [HUE_W-1:0]   HUE_GREEN = HUE_W'(120);
    localparam logic [HUE_W-1:0]   HUE_BLUE  = HUE_W'(240);
    localparam logic [SUM_W-1:0]   SUM_FULL  = SUM_W'(200);
    localparam logic [PCT_W-1:0]   LIT_HALF  = PCT_W'(50);

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        logic [CNT_W-1:0] clear_count;
        logic [CNT_W-1:0] red_count;
        logic [CNT_W-1:0] green_count;
        logic [CNT_W-1:0] blue_count;
    } in_item_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] saturation_pct;
        logic [PCT_W-1:0] lightness_pct;
        logic             zero_clear_error;
    } out_item_t;

    typedef struct packed {
        logic                      zero;
        logic [NCH-1:0][PCT_W-1:0] pct;
    } pct_item_t;

endpackage

>>> src/rgbhsl_pct.sv
module rgbhsl_pct import rgbhsl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pct_item_t out_data
);

    logic st1_valid_reg, st2_valid_reg, st3_valid_reg;
    logic en1, en2, en3;

    logic [NCH-1:0][CNT_W-1:0]     counts;
    logic [NCH-1:0][PCT_NUM_W-1:0] st1_num_reg, st1_num_next;
    logic [NCH-1:0]                st1_big_reg, st1_big_next;
    logic [CNT_W-1:0]              st1_clear_reg;
    logic                          st1_zero_reg, st1_zero_next;

    logic [NCH-1:0][PCT_NUM_W-1:0] st2_rem_reg, st2_rem_next;
    logic [NCH-1:0][PCT_W-1:0]     st2_quo_reg, st2_quo_next;
    logic [NCH-1:0]                st2_big_reg;
    logic [CNT_W-1:0]              st2_clear_reg;
    logic                          st2_zero_reg;

    logic [NCH-1:0][PCT_W-1:0]     st3_pct_reg, st3_pct_next;
    logic                          st3_zero_reg;

    assign en3      = !st3_valid_reg || out_ready;
    assign en2      = !st2_valid_reg || en3;
    assign en1      = !st1_valid_reg || en2;
    assign in_ready = en1;

    assign counts[CH_RED]   = in_data.red_count;
    assign counts[CH_GREEN] = in_data.green_count;
    assign counts[CH_BLUE]  = in_data.blue_count;

    // scale by 100; a count at or above clear saturates to 100
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            st1_num_next[c] = PCT_NUM_W'(counts[c]) * PCT_NUM_W'(PCT_FULL);
            st1_big_next[c] = counts[c] >= in_data.clear_count;
        end
        st1_zero_next = in_data.clear_count == '0;
    end

    // quotient bits 6..4
    always_comb begin
        logic [PCT_NUM_W-1:0] rem;
        logic [PCT_NUM_W-1:0] dsh;
        logic [PCT_W-1:0]     quo;
        rem = '0;
        dsh = '0;
        quo = '0;
        for (int c = 0; c < NCH; c++) begin
            rem = st1_num_reg[c];
            quo = '0;
            for (int i = PCT_W - 1; i >= 4; i--) begin
                dsh = PCT_NUM_W'(st1_clear_reg) << i;
                if (rem >= dsh) begin
                    rem    = rem - dsh;
                    quo[i] = 1'b1;
                end
            end
            st2_rem_next[c] = rem;
            st2_quo_next[c] = quo;
        end
    end

    // quotient bits 3..0, then clamp
    always_comb begin
        logic [PCT_NUM_W-1:0] rem;
        logic [PCT_NUM_W-1:0] dsh;
        logic [PCT_W-1:0]     quo;
        rem = '0;
        dsh = '0;
        quo = '0;
        for (int c = 0; c < NCH; c++) begin
            rem = st2_rem_reg[c];
            quo = st2_quo_reg[c];
            for (int i = 3; i >= 0; i--) begin
                dsh = PCT_NUM_W'(st2_clear_reg) << i;
                if (rem >= dsh) begin
                    rem    = rem - dsh;
                    quo[i] = 1'b1;
                end
            end
            st3_pct_next[c] = st2_big_reg[c] ? PCT_FULL : quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                st1_valid_reg <= in_valid;
            end
            if (en2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3) begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            st1_num_reg   <= st1_num_next;
            st1_big_reg   <= st1_big_next;
            st1_clear_reg <= in_data.clear_count;
            st1_zero_reg  <= st1_zero_next;
        end
        if (en2) begin
            st2_rem_reg   <= st2_rem_next;
            st2_quo_reg   <= st2_quo_next;
            st2_big_reg   <= st1_big_reg;
            st2_clear_reg <= st1_clear_reg;
            st2_zero_reg  <= st1_zero_reg;
        end
        if (en3) begin
            st3_pct_reg  <= st3_pct_next;
            st3_zero_reg <= st2_zero_reg;
        end
    end

    assign out_valid     = st3_valid_reg;
    assign out_data.zero = st3_zero_reg;
    assign out_data.pct  = st3_pct_reg;

endmodule

>>> src/rgbhsl_hsl.sv
module rgbhsl_hsl import rgbhsl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pct_item_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic h1_valid_reg, h2_valid_reg, h3_valid_reg, h4_valid_reg;
    logic en1, en2, en3, en4;

    logic [HUE_NUM_W-1:0] h1_hue_num_reg, h1_hue_num_next;
    logic                 h1_neg_reg, h1_neg_next;
    logic [PCT_W-1:0]     h1_dif_reg, h1_dif_next;
    logic [SAT_NUM_W-1:0] h1_sat_num_reg, h1_sat_num_next;
    logic [SUM_W-1:0]     h1_sat_den_reg, h1_sat_den_next;
    logic [PCT_W-1:0]     h1_lit_reg, h1_lit_next;
    sector_t              h1_sect_reg, h1_sect_next;
    logic                 h1_gray_reg, h1_gray_next;
    logic                 h1_zero_reg;

    logic [HUE_NUM_W-1:0] h2_hue_rem_reg, h2_hue_rem_next;
    logic [HUE_Q_W-1:0]   h2_hue_quo_reg, h2_hue_quo_next;
    logic [SAT_NUM_W-1:0] h2_sat_rem_reg, h2_sat_rem_next;
    logic [SAT_Q_W-1:0]   h2_sat_quo_reg, h2_sat_quo_next;
    logic [PCT_W-1:0]     h2_dif_reg;
    logic [SUM_W-1:0]     h2_sat_den_reg;
    logic                 h2_neg_reg;
    logic [PCT_W-1:0]     h2_lit_reg;
    sector_t              h2_sect_reg;
    logic                 h2_gray_reg;
    logic                 h2_zero_reg;

    logic [HUE_Q_W-1:0]   h3_hue_quo_reg, h3_hue_quo_next;
    logic [SAT_Q_W-1:0]   h3_sat_quo_reg, h3_sat_quo_next;
    logic                 h3_neg_reg;
    logic [PCT_W-1:0]     h3_lit_reg;
    sector_t              h3_sect_reg;
    logic                 h3_gray_reg;
    logic                 h3_zero_reg;

    out_item_t            h4_out_reg, h4_out_next;

    assign en4      = !h4_valid_reg || out_ready;
    assign en3      = !h3_valid_reg || en4;
    assign en2      = !h2_valid_reg || en3;
    assign en1      = !h1_valid_reg || en2;
    assign in_ready = en1;

    // sector, extremes, dividends and divisors
    always_comb begin
        logic [PCT_W-1:0] r, g, b, mx, mn, x, y, mag;
        logic [SUM_W-1:0] sum;
        r = in_data.pct[CH_RED];
        g = in_data.pct[CH_GREEN];
        b = in_data.pct[CH_BLUE];
        if (r >= g && r >= b) begin
            h1_sect_next = SECT_RED;
            mx = r;
            x  = g;
            y  = b;
        end else if (g >= b) begin
            h1_sect_next = SECT_GREEN;
            mx = g;
            x  = b;
            y  = r;
        end else begin
            h1_sect_next = SECT_BLUE;
            mx = b;
            x  = r;
            y  = g;
        end
        mn = r;
        if (g < mn) begin
            mn = g;
        end
        if (b < mn) begin
            mn = b;
        end
        h1_dif_next  = mx - mn;
        h1_gray_next = mx == mn;
        sum          = SUM_W'(mx) + SUM_W'(mn);
        h1_lit_next  = sum[SUM_W-1:1];
        h1_neg_next  = x < y;
        mag          = h1_neg_next ? (y - x) : (x - y);
        h1_hue_num_next = HUE_NUM_W'(mag) * HUE_NUM_W'(HUE_STEP);
        h1_sat_num_next = SAT_NUM_W'(h1_dif_next) * SAT_NUM_W'(PCT_FULL);
        h1_sat_den_next = (h1_lit_next <= LIT_HALF) ? sum : (SUM_FULL - sum);
    end

    // upper quotient bits
    always_comb begin
        logic [HUE_NUM_W-1:0] hrem, hdsh;
        logic [HUE_Q_W-1:0]   hquo;
        logic [SAT_NUM_W-1:0] srem, sdsh;
        logic [SAT_Q_W-1:0]   squo;
        hrem = h1_hue_num_reg;
        hdsh = '0;
        hquo = '0;
        srem = h1_sat_num_reg;
        sdsh = '0;
        squo = '0;
        for (int i = HUE_Q_W - 1; i >= 3; i--) begin
            hdsh = HUE_NUM_W'(h1_dif_reg) << i;
            if (hrem >= hdsh) begin
                hrem    = hrem - hdsh;
                hquo[i] = 1'b1;
            end
        end
        for (int i = SAT_Q_W - 1; i >= 4; i--) begin
            sdsh = SAT_NUM_W'(h1_sat_den_reg) << i;
            if (srem >= sdsh) begin
                srem    = srem - sdsh;
                squo[i] = 1'b1;
            end
        end
        h2_hue_rem_next = hrem;
        h2_hue_quo_next = hquo;
        h2_sat_rem_next = srem;
        h2_sat_quo_next = squo;
    end

    // lower quotient bits
    always_comb begin
        logic [HUE_NUM_W-1:0] hrem, hdsh;
        logic [HUE_Q_W-1:0]   hquo;
        logic [SAT_NUM_W-1:0] srem, sdsh;
        logic [SAT_Q_W-1:0]   squo;
        hrem = h2_hue_rem_reg;
        hdsh = '0;
        hquo = h2_hue_quo_reg;
        srem = h2_sat_rem_reg;
        sdsh = '0;
        squo = h2_sat_quo_reg;
        for (int i = 2; i >= 0; i--) begin
            hdsh = HUE_NUM_W'(h2_dif_reg) << i;
            if (hrem >= hdsh) begin
                hrem    = hrem - hdsh;
                hquo[i] = 1'b1;
            end
        end
        for (int i = 3; i >= 0; i--) begin
            sdsh = SAT_NUM_W'(h2_sat_den_reg) << i;
            if (srem >= sdsh) begin
                srem    = srem - sdsh;
                squo[i] = 1'b1;
            end
        end
        h3_hue_quo_next = hquo;
        h3_sat_quo_next = squo;
    end

    // sector offset, wrap of 360, gray and zero-clear forcing
    always_comb begin
        logic [HUE_W-1:0] q;
        logic [HUE_W-1:0] hue;
        q = HUE_W'(h3_hue_quo_reg);
        case (h3_sect_reg)
            SECT_RED: begin
                hue = h3_neg_reg ? (HUE_FULL - q) : q;
            end
            SECT_GREEN: begin
                hue = h3_neg_reg ? (HUE_GREEN - q) : (HUE_GREEN + q);
            end
            SECT_BLUE: begin
                hue = h3_neg_reg ? (HUE_BLUE - q) : (HUE_BLUE + q);
            end
            default: begin
                hue = '0;
            end
        endcase
        if (hue == HUE_FULL) begin
            hue = '0;
        end
        h4_out_next.hue_deg          = (h3_gray_reg || h3_zero_reg) ? '0 : hue;
        h4_out_next.saturation_pct   = (h3_gray_reg || h3_zero_reg) ? '0 : h3_sat_quo_reg;
        h4_out_next.lightness_pct    = h3_zero_reg ? '0 : h3_lit_reg;
        h4_out_next.zero_clear_error = h3_zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h1_valid_reg <= 1'b0;
            h2_valid_reg <= 1'b0;
            h3_valid_reg <= 1'b0;
            h4_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                h1_valid_reg <= in_valid;
            end
            if (en2) begin
                h2_valid_reg <= h1_valid_reg;
            end
            if (en3) begin
                h3_valid_reg <= h2_valid_reg;
            end
            if (en4) begin
                h4_valid_reg <= h3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            h1_hue_num_reg <= h1_hue_num_next;
            h1_neg_reg     <= h1_neg_next;
            h1_dif_reg     <= h1_dif_next;
            h1_sat_num_reg <= h1_sat_num_next;
            h1_sat_den_reg <= h1_sat_den_next;
            h1_lit_reg     <= h1_lit_next;
            h1_sect_reg    <= h1_sect_next;
            h1_gray_reg    <= h1_gray_next;
            h1_zero_reg    <= in_data.zero;
        end
        if (en2) begin
            h2_hue_rem_reg <= h2_hue_rem_next;
            h2_hue_quo_reg <= h2_hue_quo_next;
            h2_sat_rem_reg <= h2_sat_rem_next;
            h2_sat_quo_reg <= h2_sat_quo_next;
            h2_dif_reg     <= h1_dif_reg;
            h2_sat_den_reg <= h1_sat_den_reg;
            h2_neg_reg     <= h1_neg_reg;
            h2_lit_reg     <= h1_lit_reg;
            h2_sect_reg    <= h1_sect_reg;
            h2_gray_reg    <= h1_gray_reg;
            h2_zero_reg    <= h1_zero_reg;
        end
        if (en3) begin
            h3_hue_quo_reg <= h3_hue_quo_next;
            h3_sat_quo_reg <= h3_sat_quo_next;
            h3_neg_reg     <= h2_neg_reg;
            h3_lit_reg     <= h2_lit_reg;
            h3_sect_reg    <= h2_sect_reg;
            h3_gray_reg    <= h2_gray_reg;
            h3_zero_reg    <= h2_zero_reg;
        end
        if (en4) begin
            h4_out_reg <= h4_out_next;
        end
    end

    assign out_valid = h4_valid_reg;
    assign out_data  = h4_out_reg;

endmodule

>>> src/rgbc_to_hsl_converter_top.sv
// Throughput: one item per cycle when the output side is not stalled; seven register stages
// (three for the percent divide, four for hue/saturation divide and final assembly), each
// with its own valid bit.
// A stalled stage only holds items upstream of it; bubbles are squeezed out.
// Reset: synchronous, active low; clears all stage valid bits, data registers keep state.
module rgbc_to_hsl_converter_top import rgbhsl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      pct_valid;
    logic      pct_ready;
    pct_item_t pct_data;

    rgbhsl_pct u_pct (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (pct_valid),
        .out_ready (pct_ready),
        .out_data  (pct_data)
    );

    rgbhsl_hsl u_hsl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pct_valid),
        .in_ready  (pct_ready),
        .in_data   (pct_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

>>> src/rgbhsl_checker.sv
`include "rgbc_to_hsl_converter_top_defines.svh"

module rgbhsl_checker import rgbhsl_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `RGBHSL_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready, "pipeline not empty after reset")

    `RGBHSL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "stalled item changed")

    `RGBHSL_ASSERT_NOW(a_zero_clear, aclk, aresetn, m_valid && m_data.zero_clear_error, m_data.hue_deg == '0 && m_data.saturation_pct == '0 && m_data.lightness_pct == '0, "zero-clear item has nonzero fields")

    `RGBHSL_ASSERT_NOW(a_range, aclk, aresetn, m_valid, m_data.hue_deg < HUE_FULL && m_data.saturation_pct <= PCT_FULL && m_data.lightness_pct <= PCT_FULL, "result out of range")

endmodule

bind rgbc_to_hsl_converter_top rgbhsl_checker u_rgbhsl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
